@@ rtl/core/apm_pkg.sv @@
package apm_pkg;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FLOOR_DB        = 2'd0;
    localparam t_cfg_idx CFG_CEILING_DB      = 2'd1;
    localparam t_cfg_idx CFG_REPORT_INTERVAL = 2'd2;

    // register reset values
    localparam logic signed [15:0] FLOOR_DB_RST        = -16'sd10240;
    localparam logic signed [15:0] CEILING_DB_RST      = 16'sd0;
    localparam logic        [15:0] REPORT_INTERVAL_RST = 16'd4800;

    // 20*log10(2) in 1/256 dB, scaled by 2^32 / 2^16
    localparam int unsigned       DB_BITS         = 27;
    localparam logic [DB_BITS-1:0] DB_PER_OCTAVE  = 27'd101008905;

    // log2 fraction bits and divider steps
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned VU_BITS   = 13;

    // value reported for a zero peak
    localparam logic signed [15:0] DB_FLOOR = 16'sh8000;

endpackage

@@ rtl/core/audio_peak_level_meter.sv @@
// Audio peak level meter.
// Input channel (i_in_valid / o_in_stall / i_sample): one signed sample per
// transaction. A sample that does not close a report interval gives no
// result, so such samples stream at one per cycle while o_in_stall is low.
// The sample that makes the count reach report_interval starts the report
// math: a normalize shift (one bit a cycle), 16 squaring steps for the
// log2 fraction, a multiply by the dB constant, the VU clamp and compare,
// and a 13 bit restoring divide, under a small sequencer; the squaring and
// the dB multiply share one multiplier. A full scale peak skips the
// multiply, a ratio under 0.30 skips the divide and a zero peak goes
// straight to the VU step. o_in_stall stays high meanwhile.
// Output channel (o_out_valid / i_out_stall / o_peak_*): one report per
// transaction, held in an output register. While the receiver stalls, the
// register holds and non-reporting samples are still accepted; a new report
// waits in its last step until the register frees up.
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
// always ready and is meant to be written while the block is idle.
// Synchronous active-low reset clears the peak, the count and the output
// valid, and loads the register defaults.
module audio_peak_level_meter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // report channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic        [15:0]            o_peak_raw,
    output logic signed [15:0]            o_peak_db,
    output logic        [12:0]            o_peak_vu,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  apm_pkg::t_cfg_idx             i_cfg_index,
    input  logic        [15:0]            i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int EW = $clog2(SAMPLE_BITS);
    localparam int MA = EW + 16;
    localparam int MB = apm_pkg::DB_BITS;
    localparam int PW = MA + MB;
    localparam int FB = apm_pkg::FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQ, S_LOG, S_MUL, S_RND, S_VU1, S_VU2, S_DIV, S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [SB-1:0]           r_peak, n_peak;
    logic [15:0]             r_count, n_count;
    logic signed [15:0]      r_floor, n_floor;
    logic signed [15:0]      r_ceil, n_ceil;
    logic [15:0]             r_interval, n_interval;
    logic [SB-1:0]           r_norm, n_norm;
    logic [EW-1:0]           r_shift, n_shift;
    logic [16:0]             r_x, n_x;
    logic [FB-1:0]           r_frac, n_frac;
    logic [3:0]              r_step, n_step;
    logic [MA-1:0]           r_negl, n_negl;
    logic [PW-1:0]           r_prod, n_prod;
    logic signed [15:0]      r_db, n_db;
    logic [15:0]             r_raw, n_raw;
    logic [15:0]             r_dd, n_dd;
    logic [15:0]             r_range, n_range;
    logic                    r_ok, n_ok;
    logic [16:0]             r_rem, n_rem;
    logic [12:0]             r_quot, n_quot;
    logic                    r_out_valid, n_out_valid;
    logic [15:0]             r_out_raw, n_out_raw;
    logic signed [15:0]      r_out_db, n_out_db;
    logic [12:0]             r_out_vu, n_out_vu;

    // sample magnitude and running peak
    logic [SB-1:0]           mag;
    logic [SB-1:0]           new_peak;
    logic [15:0]             new_count;
    logic                    report;
    logic [SB+15:0]          peak_ext;
    logic [SB+16:0]          norm_wide;

    assign mag       = i_sample[SB-1] ? (SB)'(-i_sample) : i_sample;
    assign new_peak  = (mag > r_peak) ? mag : r_peak;
    assign new_count = r_count + 16'd1;
    assign report    = (new_count >= r_interval);
    assign peak_ext  = {16'b0, new_peak};
    assign norm_wide = {r_norm, 17'b0};

    // shared multiplier: mantissa squaring or dB scaling
    logic [MA-1:0]           mul_a;
    logic [MB-1:0]           mul_b;
    logic [PW-1:0]           mul_p;
    logic [17:0]             sq;

    always_comb begin
        if (r_state == S_SQ) begin
            mul_a = {{(MA-17){1'b0}}, r_x};
            mul_b = {{(MB-17){1'b0}}, r_x};
        end else begin
            mul_a = r_negl;
            mul_b = apm_pkg::DB_PER_OCTAVE;
        end
    end
    assign mul_p = mul_a * mul_b;
    assign sq    = mul_p[33:16];

    // rounding of the scaled log
    logic [PW:0]             rnd_sum;
    logic [31:0]             db_mag;
    assign rnd_sum = {1'b0, r_prod} + {{(PW-31){1'b0}}, 32'h8000_0000};
    assign db_mag  = 32'(rnd_sum[PW:32]);

    // VU clamp
    logic signed [16:0]      db17, lo17, hi17, d17, dd17, rng17;
    assign db17  = 17'(r_db);
    assign lo17  = 17'(r_floor);
    assign hi17  = 17'(r_ceil);
    assign rng17 = hi17 - lo17;
    always_comb begin
        d17 = db17;
        if (d17 < lo17) begin
            d17 = lo17;
        end
        if (d17 > hi17) begin
            d17 = hi17;
        end
    end
    assign dd17 = d17 - lo17;

    // 0.30 threshold and divider step
    logic [19:0]             dd_x10;
    logic [19:0]             rng_x3;
    logic [16:0]             rem_sh;
    logic [16:0]             rng_ext;
    assign dd_x10  = {1'b0, r_dd, 3'b0} + {3'b0, r_dd, 1'b0};
    assign rng_x3  = {4'b0, r_range} + {3'b0, r_range, 1'b0};
    assign rng_ext = {1'b0, r_range};
    assign rem_sh  = {r_rem[15:0], 1'b0};

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_peak_raw  = r_out_raw;
    assign o_peak_db   = r_out_db;
    assign o_peak_vu   = r_out_vu;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_peak      = r_peak;
        n_count     = r_count;
        n_floor     = r_floor;
        n_ceil      = r_ceil;
        n_interval  = r_interval;
        n_norm      = r_norm;
        n_shift     = r_shift;
        n_x         = r_x;
        n_frac      = r_frac;
        n_step      = r_step;
        n_negl      = r_negl;
        n_prod      = r_prod;
        n_db        = r_db;
        n_raw       = r_raw;
        n_dd        = r_dd;
        n_range     = r_range;
        n_ok        = r_ok;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_out_valid = r_out_valid;
        n_out_raw   = r_out_raw;
        n_out_db    = r_out_db;
        n_out_vu    = r_out_vu;

        // output transaction taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                apm_pkg::CFG_FLOOR_DB:        n_floor    = i_cfg_data;
                apm_pkg::CFG_CEILING_DB:      n_ceil     = i_cfg_data;
                apm_pkg::CFG_REPORT_INTERVAL: n_interval = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (report) begin
                        n_peak  = '0;
                        n_count = '0;
                        n_norm  = new_peak;
                        n_raw   = peak_ext[15:0];
                        n_shift = '0;
                        if (new_peak == '0) begin
                            n_db    = apm_pkg::DB_FLOOR;
                            n_state = S_VU1;
                        end else begin
                            n_state = S_NORM;
                        end
                    end else begin
                        n_peak  = new_peak;
                        n_count = new_count;
                    end
                end
            end
            S_NORM: begin
                if (r_norm[SB-1]) begin
                    n_x     = norm_wide[SB+16 -: 17];
                    n_frac  = '0;
                    n_step  = '0;
                    n_state = S_SQ;
                end else begin
                    n_norm  = {r_norm[SB-2:0], 1'b0};
                    n_shift = r_shift + 1'b1;
                end
            end
            S_SQ: begin
                n_frac = {r_frac[FB-2:0], sq[17]};
                n_x    = sq[17] ? sq[17:1] : sq[16:0];
                n_step = r_step + 4'd1;
                if (r_step == 4'(FB - 1)) begin
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                if (r_shift == '0) begin
                    n_db    = '0;
                    n_state = S_VU1;
                end else begin
                    n_negl  = {r_shift, {FB{1'b0}}} - {{EW{1'b0}}, r_frac};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_RND;
            end
            S_RND: begin
                if (db_mag >= 32'd32768) begin
                    n_db = apm_pkg::DB_FLOOR;
                end else begin
                    n_db = -$signed(db_mag[15:0]);
                end
                n_state = S_VU1;
            end
            S_VU1: begin
                n_ok    = (hi17 > lo17);
                n_dd    = dd17[15:0];
                n_range = rng17[15:0];
                n_state = S_VU2;
            end
            S_VU2: begin
                if (!r_ok || (dd_x10 < rng_x3)) begin
                    n_quot  = '0;
                    n_state = S_DONE;
                end else begin
                    n_step = '0;
                    if ({1'b0, r_dd} >= rng_ext) begin
                        n_quot = 13'd1;
                        n_rem  = {1'b0, r_dd} - rng_ext;
                    end else begin
                        n_quot = 13'd0;
                        n_rem  = {1'b0, r_dd};
                    end
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_sh >= rng_ext) begin
                    n_rem  = rem_sh - rng_ext;
                    n_quot = {r_quot[11:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_quot = {r_quot[11:0], 1'b0};
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'(apm_pkg::VU_BITS - 2)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_raw   = r_raw;
                    n_out_db    = r_db;
                    n_out_vu    = r_quot;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_peak      <= '0;
            r_count     <= '0;
            r_floor     <= apm_pkg::FLOOR_DB_RST;
            r_ceil      <= apm_pkg::CEILING_DB_RST;
            r_interval  <= apm_pkg::REPORT_INTERVAL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_peak      <= n_peak;
            r_count     <= n_count;
            r_floor     <= n_floor;
            r_ceil      <= n_ceil;
            r_interval  <= n_interval;
            r_out_valid <= n_out_valid;
        end
        r_norm    <= n_norm;
        r_shift   <= n_shift;
        r_x       <= n_x;
        r_frac    <= n_frac;
        r_step    <= n_step;
        r_negl    <= n_negl;
        r_prod    <= n_prod;
        r_db      <= n_db;
        r_raw     <= n_raw;
        r_dd      <= n_dd;
        r_range   <= n_range;
        r_ok      <= n_ok;
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_out_raw <= n_out_raw;
        r_out_db  <= n_out_db;
        r_out_vu  <= n_out_vu;
    end

    // normalize only runs on a nonzero peak
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NORM |-> r_norm != '0)
        else $error("normalize started on a zero peak");

    // mantissa stays in [1,2) through the squaring steps
    a_mant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQ |-> r_x[16])
        else $error("log2 mantissa left [1,2)");

    // divider remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < rng_ext)
        else $error("divider remainder out of range");

    // VU ratio never exceeds 1.0
    a_vu_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_quot <= 13'd4096)
        else $error("VU ratio above full scale");

    // a report clears the peak and the count
    a_report_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && report)
        |=> (r_peak == '0 && r_count == '0 && r_state != S_IDLE))
        else $error("peak or count not cleared on report");

endmodule
